[hw/rtl/sorted_priority_queue_macros.svh]
// Assertion helpers used by the checker file.
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// Clocked assertion, masked while reset is applied.
`define SPQ_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define SPQ_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/spq_pkg.sv]
`timescale 1ns / 1ps

package spq_pkg;

    typedef enum logic [1:0] {
        MODE_SORTED = 2'd0,
        MODE_FRONT  = 2'd1,
        MODE_BACK   = 2'd2,
        MODE_POP    = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_POP_RD,
        ST_POP_WR,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic popped;
        logic dropped;
        logic is_empty;
        logic is_full;
    } spq_flags_t;

endpackage

[hw/rtl/spq_ram.sv]
`timescale 1ns / 1ps

module spq_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/spq_engine.sv]
`timescale 1ns / 1ps

module spq_engine #(
    parameter int QUEUE_DEPTH   = 16,
    parameter int PRIORITY_BITS = 8,
    parameter int PAYLOAD_BITS  = 32
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    // request side
    input  logic                                     req_valid,
    output logic                                     req_ready,
    input  logic [1:0]                               req_mode,
    input  logic [PRIORITY_BITS-1:0]                 req_priority,
    input  logic [PAYLOAD_BITS-1:0]                  req_payload,
    // entry store
    output logic                                     ram_we,
    output logic [$clog2(QUEUE_DEPTH)-1:0]           ram_waddr,
    output logic [PRIORITY_BITS+PAYLOAD_BITS-1:0]    ram_wdata,
    output logic [$clog2(QUEUE_DEPTH)-1:0]           ram_raddr,
    input  logic [PRIORITY_BITS+PAYLOAD_BITS-1:0]    ram_rdata,
    // result side
    output logic                                     res_valid,
    input  logic                                     res_ready,
    output logic [PRIORITY_BITS-1:0]                 res_priority,
    output logic [PAYLOAD_BITS-1:0]                  res_payload,
    output spq_pkg::spq_flags_t                      res_flags,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]         res_occupancy
);

    import spq_pkg::*;

    localparam int ADDR_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W = PRIORITY_BITS + PAYLOAD_BITS;

    state_t                   state_reg, state_next;
    mode_t                    mode_reg, mode_next;
    logic [PRIORITY_BITS-1:0] prio_reg, prio_next;
    logic [PAYLOAD_BITS-1:0]  payload_reg, payload_next;
    logic [CNT_W-1:0]         idx_reg, idx_next;
    logic [CNT_W-1:0]         pos_reg, pos_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [PRIORITY_BITS-1:0] head_prio_reg, head_prio_next;
    logic [PAYLOAD_BITS-1:0]  head_payload_reg, head_payload_next;
    logic [PRIORITY_BITS-1:0] pop_prio_reg, pop_prio_next;
    logic [PAYLOAD_BITS-1:0]  pop_payload_reg, pop_payload_next;
    logic                     popped_reg, popped_next;
    logic                     dropped_reg, dropped_next;

    logic [PRIORITY_BITS-1:0] rd_prio;
    logic [PAYLOAD_BITS-1:0]  rd_payload;
    logic [CNT_W-1:0]         idx_dec;
    logic                     is_full_now;

    assign rd_prio     = ram_rdata[ENTRY_W-1 -: PRIORITY_BITS];
    assign rd_payload  = ram_rdata[PAYLOAD_BITS-1:0];
    assign idx_dec     = idx_reg - 1'b1;
    assign is_full_now = (count_reg == CNT_W'(QUEUE_DEPTH));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg         <= mode_next;
        prio_reg         <= prio_next;
        payload_reg      <= payload_next;
        idx_reg          <= idx_next;
        pos_reg          <= pos_next;
        head_prio_reg    <= head_prio_next;
        head_payload_reg <= head_payload_next;
        pop_prio_reg     <= pop_prio_next;
        pop_payload_reg  <= pop_payload_next;
        popped_reg       <= popped_next;
        dropped_reg      <= dropped_next;
    end

    always_comb begin
        state_next        = state_reg;
        mode_next         = mode_reg;
        prio_next         = prio_reg;
        payload_next      = payload_reg;
        idx_next          = idx_reg;
        pos_next          = pos_reg;
        count_next        = count_reg;
        head_prio_next    = head_prio_reg;
        head_payload_next = head_payload_reg;
        pop_prio_next     = pop_prio_reg;
        pop_payload_next  = pop_payload_reg;
        popped_next       = popped_reg;
        dropped_next      = dropped_reg;

        req_ready = 1'b0;
        res_valid = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = idx_reg[ADDR_W-1:0];
        ram_wdata = ram_rdata;
        ram_raddr = idx_reg[ADDR_W-1:0];

        case (state_reg)
            ST_IDLE: begin
                req_ready = 1'b1;
                if (req_valid) begin
                    mode_next    = mode_t'(req_mode);
                    prio_next    = req_priority;
                    payload_next = req_payload;
                    popped_next  = 1'b0;
                    dropped_next = 1'b0;
                    if (mode_t'(req_mode) == MODE_POP) begin
                        if (count_reg == '0) begin
                            state_next = ST_DONE;
                        end else begin
                            pop_prio_next    = head_prio_reg;
                            pop_payload_next = head_payload_reg;
                            popped_next      = 1'b1;
                            idx_next         = CNT_W'(1);
                            state_next       = ST_POP_RD;
                        end
                    end else if (is_full_now) begin
                        dropped_next = 1'b1;
                        state_next   = ST_DONE;
                    end else begin
                        case (mode_t'(req_mode))
                            MODE_SORTED: begin
                                idx_next   = '0;
                                state_next = ST_SCAN_RD;
                            end
                            MODE_FRONT: begin
                                pos_next   = '0;
                                idx_next   = count_reg;
                                state_next = ST_SHIFT_RD;
                            end
                            default: begin
                                pos_next   = count_reg;
                                idx_next   = count_reg;
                                state_next = ST_SHIFT_RD;
                            end
                        endcase
                    end
                end
            end

            // walk from the head until a stored priority is not lower
            ST_SCAN_RD: begin
                if (idx_reg == count_reg) begin
                    pos_next   = idx_reg;
                    state_next = ST_SHIFT_RD;
                end else begin
                    state_next = ST_SCAN_CMP;
                end
            end

            ST_SCAN_CMP: begin
                if (rd_prio < prio_reg) begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_SCAN_RD;
                end else begin
                    pos_next   = idx_reg;
                    idx_next   = count_reg;
                    state_next = ST_SHIFT_RD;
                end
            end

            // open the gap from the tail down to pos, then drop the entry in
            ST_SHIFT_RD: begin
                if (idx_reg > pos_reg) begin
                    ram_raddr  = idx_dec[ADDR_W-1:0];
                    state_next = ST_SHIFT_WR;
                end else begin
                    ram_we     = 1'b1;
                    ram_waddr  = pos_reg[ADDR_W-1:0];
                    ram_wdata  = {prio_reg, payload_reg};
                    count_next = count_reg + 1'b1;
                    if (pos_reg == '0) begin
                        head_prio_next    = prio_reg;
                        head_payload_next = payload_reg;
                    end
                    state_next = ST_DONE;
                end
            end

            ST_SHIFT_WR: begin
                ram_we     = 1'b1;
                ram_waddr  = idx_reg[ADDR_W-1:0];
                idx_next   = idx_dec;
                state_next = ST_SHIFT_RD;
            end

            // close the gap left by the head
            ST_POP_RD: begin
                if (idx_reg < count_reg) begin
                    state_next = ST_POP_WR;
                end else begin
                    count_next = count_reg - 1'b1;
                    state_next = ST_DONE;
                end
            end

            ST_POP_WR: begin
                ram_we    = 1'b1;
                ram_waddr = idx_dec[ADDR_W-1:0];
                if (idx_reg == CNT_W'(1)) begin
                    head_prio_next    = rd_prio;
                    head_payload_next = rd_payload;
                end
                idx_next   = idx_reg + 1'b1;
                state_next = ST_POP_RD;
            end

            ST_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (popped_reg) begin
            res_priority = pop_prio_reg;
            res_payload  = pop_payload_reg;
        end else if (count_reg != '0) begin
            res_priority = head_prio_reg;
            res_payload  = head_payload_reg;
        end else begin
            res_priority = '0;
            res_payload  = '0;
        end
        res_flags.popped   = popped_reg;
        res_flags.dropped  = dropped_reg;
        res_flags.is_empty = (count_reg == '0);
        res_flags.is_full  = is_full_now;
        res_occupancy      = count_reg;
    end

endmodule

[hw/rtl/spq_out.sv]
`timescale 1ns / 1ps

module spq_out #(
    parameter int QUEUE_DEPTH   = 16,
    parameter int PRIORITY_BITS = 8,
    parameter int PAYLOAD_BITS  = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             res_valid,
    output logic                             res_ready,
    input  logic [PRIORITY_BITS-1:0]         res_priority,
    input  logic [PAYLOAD_BITS-1:0]          res_payload,
    input  spq_pkg::spq_flags_t              res_flags,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0] res_occupancy,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [PRIORITY_BITS-1:0]         m_out_priority,
    output logic [PAYLOAD_BITS-1:0]          m_out_payload,
    output logic                             m_popped,
    output logic                             m_dropped,
    output logic                             m_is_empty,
    output logic                             m_is_full,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] m_occupancy
);

    import spq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic                     valid_reg, valid_next;
    logic [PRIORITY_BITS-1:0] prio_reg;
    logic [PAYLOAD_BITS-1:0]  payload_reg;
    spq_flags_t               flags_reg;
    logic [CNT_W-1:0]         occ_reg;
    logic                     load;

    assign res_ready = !valid_reg || m_ready;
    assign load      = res_valid && res_ready;

    always_comb begin
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            prio_reg    <= res_priority;
            payload_reg <= res_payload;
            flags_reg   <= res_flags;
            occ_reg     <= res_occupancy;
        end
    end

    assign m_valid        = valid_reg;
    assign m_out_priority = prio_reg;
    assign m_out_payload  = payload_reg;
    assign m_popped       = flags_reg.popped;
    assign m_dropped      = flags_reg.dropped;
    assign m_is_empty     = flags_reg.is_empty;
    assign m_is_full      = flags_reg.is_full;
    assign m_occupancy    = occ_reg;

endmodule

[hw/rtl/sorted_priority_queue.sv]
// Bounded sorted queue of {priority, payload} entries, lowest priority first.
// Input channel s_*: one request per transaction; s_mode selects sorted insert,
// push front, push back or pop front. Output channel m_*: exactly one result
// per request with the popped entry (or the head), flags and occupancy.
// Entries live in a single-port-write / registered-read RAM; one sequencer
// reuses one address path and one priority comparator to scan and shift it.
// Entries move through the RAM one at a time, a read and then a write, so push
// front, pop front and sorted insert take longer the more entries are stored;
// a full drop, an empty pop and a push back move no entries.
// The result is loaded into an output register at the edge that ends the
// transaction, so m_valid rises as s_ready returns; s_ready is high only while
// the sequencer is idle, and a new request may be taken while a finished
// result still sits in the output register.
// If m_ready stays low the result holds and the next request stalls at its
// final step. Reset (aresetn low, synchronous) empties the queue and drops
// any pending result; stored entries are not cleared.
`timescale 1ns / 1ps

module sorted_priority_queue #(
    parameter int QUEUE_DEPTH   = 16,
    parameter int PRIORITY_BITS = 8,
    parameter int PAYLOAD_BITS  = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [1:0]                       s_mode,
    input  logic [PRIORITY_BITS-1:0]         s_in_priority,
    input  logic [PAYLOAD_BITS-1:0]          s_in_payload,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [PRIORITY_BITS-1:0]         m_out_priority,
    output logic [PAYLOAD_BITS-1:0]          m_out_payload,
    output logic                             m_popped,
    output logic                             m_dropped,
    output logic                             m_is_empty,
    output logic                             m_is_full,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] m_occupancy
);

    import spq_pkg::*;

    localparam int ADDR_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W = PRIORITY_BITS + PAYLOAD_BITS;

    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_waddr;
    logic [ENTRY_W-1:0]       ram_wdata;
    logic [ADDR_W-1:0]        ram_raddr;
    logic [ENTRY_W-1:0]       ram_rdata;

    logic                     res_valid;
    logic                     res_ready;
    logic [PRIORITY_BITS-1:0] res_priority;
    logic [PAYLOAD_BITS-1:0]  res_payload;
    spq_flags_t               res_flags;
    logic [CNT_W-1:0]         res_occupancy;

    spq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    spq_engine #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .PRIORITY_BITS (PRIORITY_BITS),
        .PAYLOAD_BITS  (PAYLOAD_BITS)
    ) u_engine (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .req_valid     (s_valid),
        .req_ready     (s_ready),
        .req_mode      (s_mode),
        .req_priority  (s_in_priority),
        .req_payload   (s_in_payload),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata),
        .ram_raddr     (ram_raddr),
        .ram_rdata     (ram_rdata),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res_priority  (res_priority),
        .res_payload   (res_payload),
        .res_flags     (res_flags),
        .res_occupancy (res_occupancy)
    );

    spq_out #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .PRIORITY_BITS (PRIORITY_BITS),
        .PAYLOAD_BITS  (PAYLOAD_BITS)
    ) u_out (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .res_priority   (res_priority),
        .res_payload    (res_payload),
        .res_flags      (res_flags),
        .res_occupancy  (res_occupancy),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_priority (m_out_priority),
        .m_out_payload  (m_out_payload),
        .m_popped       (m_popped),
        .m_dropped      (m_dropped),
        .m_is_empty     (m_is_empty),
        .m_is_full      (m_is_full),
        .m_occupancy    (m_occupancy)
    );

endmodule

[hw/rtl/spq_checker.sv]
`timescale 1ns / 1ps
`include "sorted_priority_queue_macros.svh"

module spq_checker #(
    parameter int QUEUE_DEPTH   = 16,
    parameter int PRIORITY_BITS = 8,
    parameter int PAYLOAD_BITS  = 32
) (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input logic [1:0]                       s_mode,
    input logic [PRIORITY_BITS-1:0]         s_in_priority,
    input logic [PAYLOAD_BITS-1:0]          s_in_payload,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic [PRIORITY_BITS-1:0]         m_out_priority,
    input logic [PAYLOAD_BITS-1:0]          m_out_payload,
    input logic                             m_popped,
    input logic                             m_dropped,
    input logic                             m_is_empty,
    input logic                             m_is_full,
    input logic [$clog2(QUEUE_DEPTH+1)-1:0] m_occupancy
);

    // empty flag must agree with the reported count
    `SPQ_ASSERT(a_empty_count, aclk, aresetn, m_valid |-> (m_is_empty == (m_occupancy == '0)), "empty flag disagrees with occupancy")

    // a refused insert can only happen on a full queue
    `SPQ_ASSERT(a_drop_full, aclk, aresetn, (m_valid && m_dropped) |-> (m_is_full && !m_popped), "drop reported while not full")

    // no entry to report when empty and nothing was popped
    `SPQ_ASSERT(a_empty_zero, aclk, aresetn, (m_valid && m_is_empty && !m_popped) |-> (m_out_priority == '0 && m_out_payload == '0), "nonzero entry on empty queue")

    // a stalled result keeps its payload and occupancy
    `SPQ_ASSERT(a_out_hold, aclk, aresetn, (m_valid && !m_ready) |=> (m_valid && $stable(m_out_payload) && $stable(m_occupancy)), "result changed while stalled")

    // a waiting request holds its payload
    `SPQ_ASSERT(a_in_hold, aclk, aresetn, (s_valid && !s_ready) |=> (s_valid && $stable(s_mode) && $stable(s_in_priority) && $stable(s_in_payload)), "request changed while waiting")

endmodule

bind sorted_priority_queue spq_checker #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .PRIORITY_BITS (PRIORITY_BITS),
    .PAYLOAD_BITS  (PAYLOAD_BITS)
) u_spq_checker (.*);
